### hdl/ecgl_pkg.sv
// Package with shared types and constants of the ElGamal cipher engine.
package ecgl_pkg;

    localparam int MOD_BITS = 32;
    localparam int CNT_BITS = $clog2(MOD_BITS + 1);

    typedef logic [MOD_BITS-1:0] word_t;

    typedef enum logic [1:0]
    {
        OP_ENCRYPT = 2'd0,
        OP_DECRYPT = 2'd1,
        OP_PRODUCT = 2'd2,
        OP_UNUSED  = 2'd3
    } opcode_t;

    typedef enum logic [1:0]
    {
        MU_IDLE = 2'd0,
        MU_RUN  = 2'd1,
        MU_DONE = 2'd2
    } mu_state_t;

    typedef enum logic [4:0]
    {
        SQ_IDLE,
        SQ_RED,
        SQ_RED_WAIT,
        SQ_EXP_INIT,
        SQ_EXP_STEP,
        SQ_EXP_MUL,
        SQ_EXP_MUL_WAIT,
        SQ_EXP_SQ,
        SQ_EXP_SQ_WAIT,
        SQ_EXP_NEXT,
        SQ_PLAN,
        SQ_FMUL,
        SQ_FMUL_WAIT,
        SQ_OUT
    } seq_state_t;

    localparam logic [1:0] REG_MODULUS   = 2'd0;
    localparam logic [1:0] REG_GENERATOR = 2'd1;
    localparam logic [1:0] REG_PRIVATE   = 2'd2;

    localparam word_t RST_MODULUS   = word_t'(11);
    localparam word_t RST_GENERATOR = word_t'(2);
    localparam word_t RST_PRIVATE   = word_t'(3);

    // Request to the shared modular multiplier.
    typedef struct packed
    {
        logic  start;
        word_t x;
        word_t y;
    } mul_req_t;

    // Answer of the shared modular multiplier.
    typedef struct packed
    {
        logic  done;
        word_t product;
    } mul_rsp_t;

endpackage

### hdl/ecgl_modmul.sv
// Shared bit-serial modular multiplier (double-and-add, one bit per cycle).
module ecgl_modmul
(
    input  logic              clk,
    input  logic              rst_n,
    input  ecgl_pkg::word_t   modulus,
    input  ecgl_pkg::mul_req_t req,
    output ecgl_pkg::mul_rsp_t rsp
);
    import ecgl_pkg::*;

    mu_state_t            state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    word_t                acc_reg, acc_next;
    word_t                x_reg, x_next;
    word_t                y_reg, y_next;

    logic [MOD_BITS:0] dbl;
    word_t             dbl_r;
    logic [MOD_BITS:0] add;
    word_t             add_r;

    // Operands are below the modulus, so one conditional subtract reduces each step.
    always_comb
    begin
        dbl   = {acc_reg, 1'b0};
        dbl_r = (dbl >= {1'b0, modulus}) ? word_t'(dbl - {1'b0, modulus}) : dbl[MOD_BITS-1:0];
        add   = {1'b0, dbl_r} + {1'b0, x_reg};
        add_r = (add >= {1'b0, modulus}) ? word_t'(add - {1'b0, modulus}) : add[MOD_BITS-1:0];
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MU_IDLE: if (req.start) state_next = MU_RUN;
            MU_RUN:  if (cnt_reg == CNT_BITS'(1)) state_next = MU_DONE;
            MU_DONE: state_next = MU_IDLE;
            default: state_next = MU_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        acc_next = acc_reg;
        x_next   = x_reg;
        y_next   = y_reg;
        unique case (state_reg)
            MU_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next = CNT_BITS'(MOD_BITS);
                    acc_next = '0;
                    x_next   = req.x;
                    y_next   = req.y;
                end
            end
            MU_RUN:
            begin
                acc_next = y_reg[MOD_BITS-1] ? add_r : dbl_r;
                y_next   = {y_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign rsp.done    = (state_reg == MU_DONE);
    assign rsp.product = acc_reg;

endmodule

### hdl/ecgl_modred.sv
// Restoring bit-serial reduction of a word modulo the configured modulus.
module ecgl_modred
(
    input  logic            clk,
    input  logic            rst_n,
    input  ecgl_pkg::word_t modulus,
    input  logic            start,
    input  ecgl_pkg::word_t value,
    output logic            done,
    output ecgl_pkg::word_t remainder
);
    import ecgl_pkg::*;

    mu_state_t           state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    word_t               rem_reg, rem_next;
    word_t               val_reg, val_next;
    logic [MOD_BITS:0]   shifted;

    assign shifted = {rem_reg, val_reg[MOD_BITS-1]};

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MU_IDLE: if (start) state_next = MU_RUN;
            MU_RUN:  if (cnt_reg == CNT_BITS'(1)) state_next = MU_DONE;
            MU_DONE: state_next = MU_IDLE;
            default: state_next = MU_IDLE;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        rem_next = rem_reg;
        val_next = val_reg;
        unique case (state_reg)
            MU_IDLE:
            begin
                if (start)
                begin
                    cnt_next = CNT_BITS'(MOD_BITS);
                    rem_next = '0;
                    val_next = value;
                end
            end
            MU_RUN:
            begin
                rem_next = (shifted >= {1'b0, modulus})
                         ? word_t'(shifted - {1'b0, modulus}) : shifted[MOD_BITS-1:0];
                val_next = {val_reg[MOD_BITS-2:0], 1'b0};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MU_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        val_reg <= val_next;
    end

    assign done      = (state_reg == MU_DONE);
    assign remainder = rem_reg;

endmodule

### hdl/elgamal_cipher_engine_top.sv
// Top level of the ElGamal cipher engine: configuration port, sequencer and stream ports.
//
// The engine works on one item at a time and drops s_axis_tready while busy. A 32-bit
// modulus is used; every modular product runs on one shared bit-serial multiplier,
// and every exponentiation is square-and-multiply over all 32 exponent bits (32
// squarings plus one product per set exponent bit, so up to 64 products). Operands
// are first reduced mod p by a bit-serial reducer (six reductions per item). Encrypt
// performs three exponentiations (public key, g^k, beta^k) and a final product;
// decrypt two exponentiations and a product; product two products. The result waits
// in an output register until m_axis_tready; the next item is taken only once it has
// left. A zero modulus or an unused opcode gives an all-zero result. The user must
// write configuration only while the engine is idle, as nothing in the engine
// enforces this.
module elgamal_cipher_engine_top
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // opcode[1:0], message, ephemeral_exponent, first_c1, first_c2, second_c1,
    // second_c2 from the lowest bit up, then six zero pad bits
    input  logic [199:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // result_c1, result_c2, plaintext from the lowest bit up
    output logic [95:0]  m_axis_tdata
);
    import ecgl_pkg::*;

    // Configuration registers.
    word_t modulus_reg, generator_reg, private_reg;
    logic  cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg   <= RST_MODULUS;
            generator_reg <= RST_GENERATOR;
            private_reg   <= RST_PRIVATE;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MODULUS:   modulus_reg   <= pwdata;
                REG_GENERATOR: generator_reg <= pwdata;
                REG_PRIVATE:   private_reg   <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MODULUS:   prdata = modulus_reg;
            REG_GENERATOR: prdata = generator_reg;
            REG_PRIVATE:   prdata = private_reg;
            default:       prdata = '0;
        endcase
    end

    // Sequencer state and working registers.
    seq_state_t state_reg, state_next;
    opcode_t    op_reg, op_next;
    logic [2:0] step_reg, step_next;     // phase within the current operation
    logic [2:0] ridx_reg, ridx_next;     // operand under reduction
    word_t      opnd_reg [6];            // raw operands, all but slot 1 then reduced in place
    word_t      base_reg, base_next;
    word_t      exp_reg, exp_next;
    word_t      acc_reg, acc_next;
    logic [CNT_BITS-1:0] ecnt_reg, ecnt_next;
    word_t      beta_reg, beta_next;     // reduced generator, later the public key
    word_t      t_reg, t_next;           // reduced generator copy, later g^k
    word_t      r1_reg, r1_next, r2_reg, r2_next, pt_reg, pt_next;
    logic       out_valid_reg, out_valid_next;

    logic       load;
    logic       red_wr;
    word_t      red_val;

    mul_req_t   mreq;
    mul_rsp_t   mrsp;
    logic       red_start, red_done;
    word_t      red_rem;

    ecgl_modmul u_mul
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .modulus (modulus_reg),
        .req     (mreq),
        .rsp     (mrsp)
    );

    ecgl_modred u_red
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .modulus   (modulus_reg),
        .start     (red_start),
        .value     (red_val),
        .done      (red_done),
        .remainder (red_rem)
    );

    assign s_axis_tready = (state_reg == SQ_IDLE) && !out_valid_reg;
    assign load          = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {pt_reg, r2_reg, r1_reg};

    // Operand slots: 0 message, 1 k, 2 x1, 3 x2, 4 y1, 5 y2. Slot 1 is an exponent
    // and is never reduced; index 1 of the reduction order stands for the generator.
    always_comb
    begin
        red_val = (ridx_reg == 3'd1) ? generator_reg : opnd_reg[ridx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            for (int i = 0; i < 6; i++)
            begin
                opnd_reg[i] <= s_axis_tdata[2 + 32*i +: 32];
            end
        end
        else if (red_wr && ridx_reg != 3'd1)
        begin
            opnd_reg[ridx_reg] <= red_rem;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            SQ_IDLE:
                if (load)
                begin
                    if (modulus_reg == '0 || opcode_t'(s_axis_tdata[1:0]) == OP_UNUSED)
                        state_next = SQ_OUT;
                    else
                        state_next = SQ_RED;
                end
            SQ_RED:          state_next = SQ_RED_WAIT;
            SQ_RED_WAIT:
                if (red_done)
                    state_next = (ridx_reg == 3'd5) ? SQ_PLAN : SQ_RED;
            SQ_PLAN:         state_next = SQ_EXP_INIT;
            SQ_EXP_INIT:     state_next = SQ_EXP_STEP;
            SQ_EXP_STEP:     state_next = exp_reg[0] ? SQ_EXP_MUL : SQ_EXP_SQ;
            SQ_EXP_MUL:      state_next = SQ_EXP_MUL_WAIT;
            SQ_EXP_MUL_WAIT: if (mrsp.done) state_next = SQ_EXP_SQ;
            SQ_EXP_SQ:       state_next = SQ_EXP_SQ_WAIT;
            SQ_EXP_SQ_WAIT:  if (mrsp.done) state_next = SQ_EXP_NEXT;
            SQ_EXP_NEXT:
                state_next = (ecnt_reg == CNT_BITS'(1)) ? SQ_PLAN : SQ_EXP_STEP;
            SQ_FMUL:         state_next = SQ_FMUL_WAIT;
            SQ_FMUL_WAIT:    if (mrsp.done) state_next = SQ_PLAN;
            SQ_OUT:          state_next = SQ_IDLE;
            default:         state_next = SQ_IDLE;
        endcase
        // The plan step jumps straight to a product, the output, or an exponentiation.
        if (state_reg == SQ_PLAN)
        begin
            unique case (op_reg)
                OP_ENCRYPT:
                    state_next = (step_reg == 3'd3) ? SQ_FMUL
                               : (step_reg == 3'd4) ? SQ_OUT : SQ_EXP_INIT;
                OP_DECRYPT:
                    state_next = (step_reg == 3'd2) ? SQ_FMUL
                               : (step_reg == 3'd3) ? SQ_OUT : SQ_EXP_INIT;
                default:
                    state_next = (step_reg == 3'd2) ? SQ_OUT : SQ_FMUL;
            endcase
        end
    end

    // Datapath control.
    always_comb
    begin
        op_next        = op_reg;
        step_next      = step_reg;
        ridx_next      = ridx_reg;
        base_next      = base_reg;
        exp_next       = exp_reg;
        acc_next       = acc_reg;
        ecnt_next      = ecnt_reg;
        beta_next      = beta_reg;
        t_next         = t_reg;
        r1_next        = r1_reg;
        r2_next        = r2_reg;
        pt_next        = pt_reg;
        out_valid_next = out_valid_reg;
        red_start      = 1'b0;
        red_wr         = 1'b0;
        mreq.start     = 1'b0;
        mreq.x         = acc_reg;
        mreq.y         = base_reg;
        if (out_valid_reg && m_axis_tready)
            out_valid_next = 1'b0;
        unique case (state_reg)
            SQ_IDLE:
            begin
                if (load)
                begin
                    op_next   = opcode_t'(s_axis_tdata[1:0]);
                    step_next = '0;
                    ridx_next = '0;
                    r1_next   = '0;
                    r2_next   = '0;
                    pt_next   = '0;
                end
            end
            SQ_RED:
                red_start = 1'b1;
            SQ_RED_WAIT:
            begin
                if (red_done)
                begin
                    red_wr = 1'b1;
                    if (ridx_reg == 3'd1)
                        beta_next = red_rem;      // reduced generator
                    ridx_next = ridx_reg + 3'd1;
                end
            end
            SQ_PLAN:
            begin
                step_next = step_reg + 3'd1;
                // Choose the base and exponent of the next power.
                unique case (op_reg)
                    OP_ENCRYPT:
                    begin
                        unique case (step_reg)
                            3'd0:    begin t_next = beta_reg; base_next = beta_reg;
                                           exp_next = private_reg; end
                            3'd1:    begin beta_next = acc_reg; base_next = t_reg;
                                           exp_next = opnd_reg[1]; end
                            3'd2:    begin t_next = acc_reg; base_next = beta_reg;
                                           exp_next = opnd_reg[1]; end
                            3'd3:    begin r1_next = t_reg; end
                            default: ;
                        endcase
                    end
                    OP_DECRYPT:
                    begin
                        unique case (step_reg)
                            3'd0:    begin base_next = opnd_reg[2]; exp_next = private_reg; end
                            3'd1:    begin base_next = acc_reg;
                                           exp_next = modulus_reg - word_t'(2); end
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            SQ_EXP_INIT:
            begin
                // One reduced mod p: zero only when p is one.
                acc_next  = (modulus_reg == word_t'(1)) ? '0 : word_t'(1);
                ecnt_next = CNT_BITS'(MOD_BITS);
            end
            SQ_EXP_MUL:
                mreq.start = 1'b1;
            SQ_EXP_MUL_WAIT:
                if (mrsp.done) acc_next = mrsp.product;
            SQ_EXP_SQ:
            begin
                mreq.start = 1'b1;
                mreq.x     = base_reg;
            end
            SQ_EXP_SQ_WAIT:
                if (mrsp.done) base_next = mrsp.product;
            SQ_EXP_NEXT:
            begin
                exp_next  = exp_reg >> 1;
                ecnt_next = ecnt_reg - CNT_BITS'(1);
            end
            SQ_FMUL:
            begin
                mreq.start = 1'b1;
                unique case (op_reg)
                    OP_ENCRYPT: begin mreq.x = opnd_reg[0]; mreq.y = acc_reg; end
                    OP_DECRYPT: begin mreq.x = opnd_reg[3]; mreq.y = acc_reg; end
                    default:
                    begin
                        mreq.x = (step_reg == 3'd1) ? opnd_reg[2] : opnd_reg[3];
                        mreq.y = (step_reg == 3'd1) ? opnd_reg[4] : opnd_reg[5];
                    end
                endcase
            end
            SQ_FMUL_WAIT:
            begin
                if (mrsp.done)
                begin
                    unique case (op_reg)
                        OP_ENCRYPT: r2_next = mrsp.product;
                        OP_DECRYPT: pt_next = mrsp.product;
                        default:
                            if (step_reg == 3'd1) r1_next = mrsp.product;
                            else                  r2_next = mrsp.product;
                    endcase
                end
            end
            SQ_OUT:
                out_valid_next = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= SQ_IDLE;
            out_valid_reg <= 1'b0;
            op_reg        <= OP_ENCRYPT;
            step_reg      <= '0;
            ridx_reg      <= '0;
            ecnt_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
            ridx_reg      <= ridx_next;
            ecnt_reg      <= ecnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= base_next;
        exp_reg  <= exp_next;
        acc_reg  <= acc_next;
        beta_reg <= beta_next;
        t_reg    <= t_next;
        r1_reg   <= r1_next;
        r2_reg   <= r2_next;
        pt_reg   <= pt_next;
    end

endmodule
